// ===== rtl/core/adtlb_pkg.sv =====
// Shared types, sizes and constants for the address-space-id translation table.
// Used by the controller, the datapath and the top level; depends on nothing.
package adtlb_pkg;

  localparam int ID_COUNT = 256;
  localparam int SLOTS = 256;
  localparam int ENTRY_COUNT = ID_COUNT * SLOTS;

  localparam int KEY_W = 32;
  localparam int PHYS_W = 32;
  localparam int ACTION_W = 3;
  localparam int SPACE_W = 8;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W = KEY_W - PAGE_SHIFT;
  localparam int ID_RAW_COUNT = 256;

  localparam int ID_W = $clog2(ID_COUNT);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int REM_W = SLOT_W + 1;
  localparam int IDX_W = $clog2(ENTRY_COUNT);
  localparam int ENTRY_W = 1 + KEY_W + PHYS_W;

  localparam int RECIP_W = 32;
  localparam int PROD_W = PAGE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / SLOTS);

  localparam logic [IDX_W-1:0] ENTRY_LAST = IDX_W'(ENTRY_COUNT - 1);
  localparam logic [IDX_W-1:0] SLOT_SPAN = IDX_W'(SLOTS - 1);

  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ERASE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

  typedef logic [ID_W-1:0] id_table_t [ID_RAW_COUNT];

  function automatic id_table_t build_id_table();
    id_table_t t;
    for (int i = 0; i < ID_RAW_COUNT; i++) begin
      t[i] = ID_W'(i % ID_COUNT);
    end
    return t;
  endfunction

  localparam id_table_t ID_TAB = build_id_table();

  typedef struct packed {
    logic load;
    logic rd;
    logic wr_entry;
    logic wr_inval;
    logic sweep_all_init;
    logic sweep_id_init;
    logic sweep_wr;
    logic resp_lookup;
    logic resp_zero;
  } adtlb_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic sweep_last;
  } adtlb_status_t;

endpackage

// ===== rtl/core/adtlb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; width and depth come from its parameters.
module adtlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/adtlb_ctrl.sv =====
// Controller state machine: sequences index computation, entry access and sweeps.
// Depends on adtlb_pkg for the command and status types and the action codes.
module adtlb_ctrl import adtlb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  adtlb_status_t status,
  output adtlb_cmd_t    cmd
);

  localparam logic [2:0] ST_CLR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_P1 = 3'd2;
  localparam logic [2:0] ST_P2 = 3'd3;
  localparam logic [2:0] ST_P3 = 3'd4;
  localparam logic [2:0] ST_EXEC = 3'd5;
  localparam logic [2:0] ST_RD = 3'd6;
  localparam logic [2:0] ST_SWEEP = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_CLR: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_P1;
        end
      end
      ST_P1: state_next = ST_P2;
      ST_P2: state_next = ST_P3;
      ST_P3: state_next = ST_EXEC;
      ST_EXEC: begin
        case (status.action)
          ACT_LOOKUP: begin
            cmd.rd = 1'b1;
            state_next = ST_RD;
          end
          ACT_INSERT: begin
            cmd.wr_entry = 1'b1;
            cmd.resp_zero = 1'b1;
            state_next = ST_IDLE;
          end
          ACT_ERASE: begin
            cmd.wr_inval = 1'b1;
            cmd.resp_zero = 1'b1;
            state_next = ST_IDLE;
          end
          ACT_FLUSH: begin
            cmd.sweep_id_init = 1'b1;
            state_next = ST_SWEEP;
          end
          ACT_CLEAR: begin
            cmd.sweep_all_init = 1'b1;
            state_next = ST_SWEEP;
          end
          default: begin
            cmd.resp_zero = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_RD: begin
        cmd.resp_lookup = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          cmd.resp_zero = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/adtlb_datapath.sv =====
// Datapath: item registers, entry index arithmetic, sweep addressing, entry RAM, results.
// Depends on adtlb_pkg and instantiates adtlb_ram.
module adtlb_datapath import adtlb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  adtlb_cmd_t          cmd,
  output adtlb_status_t       status,
  input  logic [ACTION_W-1:0] action,
  input  logic [KEY_W-1:0]    virt_key,
  input  logic [PHYS_W-1:0]   phys_in,
  input  logic [SPACE_W-1:0]  space_id,
  output logic                done,
  output logic                hit,
  output logic [PHYS_W-1:0]   phys_out
);

  logic [ACTION_W-1:0] action_r;
  logic [KEY_W-1:0]    key_r;
  logic [PHYS_W-1:0]   phys_r;
  logic [SPACE_W-1:0]  sid_r;

  logic [PROD_W-1:0]   prod;
  logic [ID_W-1:0]     id_r;
  logic [REM_W-1:0]    rem;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    fbase;
  logic [IDX_W-1:0]    sw_addr;
  logic [IDX_W-1:0]    sw_end;

  logic [PAGE_W-1:0]   page;
  logic [PAGE_W-1:0]   qest;
  logic [SLOT_W-1:0]   slot;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                match;

  assign page = key_r[KEY_W-1:PAGE_SHIFT];
  assign qest = prod[PROD_W-1:RECIP_W];
  assign slot = (rem >= REM_W'(SLOTS)) ? SLOT_W'(rem - REM_W'(SLOTS)) : SLOT_W'(rem);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action;
      key_r <= virt_key;
      phys_r <= phys_in;
      sid_r <= space_id;
    end
    prod <= PROD_W'(page) * PROD_W'(RECIP);
    id_r <= ID_TAB[key_r[SPACE_W-1:0]];
    fbase <= IDX_W'(32'(ID_TAB[sid_r]) * 32'(SLOTS));
    rem <= REM_W'(32'(page) - 32'(qest) * 32'(SLOTS));
    idx <= IDX_W'(32'(id_r) * 32'(SLOTS) + 32'(slot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_addr <= '0;
      sw_end <= ENTRY_LAST;
    end else if (cmd.sweep_all_init) begin
      sw_addr <= '0;
      sw_end <= ENTRY_LAST;
    end else if (cmd.sweep_id_init) begin
      sw_addr <= fbase;
      sw_end <= fbase + SLOT_SPAN;
    end else if (cmd.sweep_wr) begin
      sw_addr <= sw_addr + IDX_W'(1);
    end
  end

  assign status.action = action_r;
  assign status.sweep_last = (sw_addr == sw_end);

  always_comb begin
    ram_we = cmd.wr_entry | cmd.wr_inval | cmd.sweep_wr;
    ram_waddr = cmd.sweep_wr ? sw_addr : idx;
    ram_wdata = cmd.wr_entry ? {1'b1, key_r, phys_r} : '0;
  end

  adtlb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRY_COUNT)
  ) u_entries (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(cmd.rd),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  assign match = ram_rdata[ENTRY_W-1] && (ram_rdata[KEY_W+PHYS_W-1:PHYS_W] == key_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resp_lookup | cmd.resp_zero;
    end
    hit <= cmd.resp_lookup & match;
    phys_out <= (cmd.resp_lookup & match) ? ram_rdata[PHYS_W-1:0] : '0;
  end

endmodule

// ===== rtl/core/asid_direct_mapped_tlb_unit.sv =====
// Top level of the address-space-id translation table: controller plus datapath.
// Depends on adtlb_pkg, adtlb_ctrl, adtlb_datapath and adtlb_ram.
// Done follows accept after the index stages, execute and, for a lookup, the RAM read;
// a flush or a clear all then sweeps its slots or all entries, one RAM write per cycle.
// A new transfer is accepted in the done cycle at the earliest.
// The receiver cannot stall; after reset busy holds high while every entry is cleared.
module asid_direct_mapped_tlb_unit import adtlb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [KEY_W-1:0]    virt_key,
  input  logic [PHYS_W-1:0]   phys_in,
  input  logic [SPACE_W-1:0]  space_id,
  output logic                done,
  output logic                hit,
  output logic [PHYS_W-1:0]   phys_out
);

  adtlb_cmd_t    cmd;
  adtlb_status_t status;

  adtlb_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .status(status),
    .cmd(cmd)
  );

  adtlb_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .action(action),
    .virt_key(virt_key),
    .phys_in(phys_in),
    .space_id(space_id),
    .done(done),
    .hit(hit),
    .phys_out(phys_out)
  );

endmodule
